// ===== hw/rtl/tbrt_pkg.sv =====
// ----------------------------------------------------------------------------
// tbrt_pkg
// Shared types and constants of the two-bitmap recent block tracker.
// ----------------------------------------------------------------------------
package tbrt_pkg;

    // field widths
    localparam int LIMIT_W = 14;
    localparam int COUNT_W = 13;
    localparam int BLK_W   = 12;

    // request kinds
    localparam logic REQ_MARK  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // recent limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd100;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr_write;    // clearing pass: stamp one entry as stale
        logic item_read;    // take the item and read its stamp
        logic eval;         // evaluate the item, update stamp, load result
        logic sweep_read;   // read the stamp under the sweep pointer
        logic sweep_check;  // age out that stamp if stale, advance pointer
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clear_last;   // clearing pass is at its last entry
        logic out_free;     // result register can take a result
    } sts_t;

endpackage

// ===== hw/rtl/tbrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbrt_ctrl
// Controller: clearing pass after reset, then per item the sequence
// accept/read, evaluate, sweep read, sweep check.
// ----------------------------------------------------------------------------
module tbrt_ctrl
    import tbrt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_SWRD  = 3'd3;
    localparam logic [2:0] ST_SWCHK = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.item_read = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.out_free) begin
                    cmd.eval   = 1'b1;
                    state_next = ST_SWRD;
                end
            end
            ST_SWRD: begin
                cmd.sweep_read = 1'b1;
                state_next     = ST_SWCHK;
            end
            ST_SWCHK: begin
                cmd.sweep_check = 1'b1;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/tbrt_dpath.sv =====
// ----------------------------------------------------------------------------
// tbrt_dpath
// Datapath: stamp memory, generation and count registers, sweep and clear
// pointers, limit register and the result register.
// A block is in the newer map when its stamp equals the generation, in the
// older map when it equals the generation minus one. A rotation changes no
// stamp but bumps generation, clears count; sweep stops old stamps aliasing after wrap.
// ----------------------------------------------------------------------------
module tbrt_dpath
    import tbrt_pkg::*;
#(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic               in_req,
    input  logic [BLK_W-1:0]   in_blk,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               out_recent,
    output logic               out_rotated
);

    localparam int AW = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
    localparam int SW = AW + 2;
    localparam int IW = (AW > BLK_W) ? AW : BLK_W;
    localparam logic [IW:0]   NUM_EXT  = (IW + 1)'(NUM_BLOCKS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);

    logic [SW-1:0]      stamp_mem [NUM_BLOCKS];
    logic [SW-1:0]      rd_data_reg;

    logic               req_reg;
    logic [BLK_W-1:0]   blk_reg;
    logic [SW-1:0]      gen_reg,   gen_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]      clr_ptr_reg;
    logic [AW-1:0]      sweep_ptr_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               out_valid_reg;
    logic               recent_reg;
    logic               rotated_reg;

    logic [IW-1:0]      in_ext, item_ext;
    logic               item_in_range;
    logic [SW-1:0]      gen_prev, gen_stale;
    logic               in_newer, in_older;
    logic               mark_set;
    logic [COUNT_W-1:0] count_inc;
    logic               rotate;
    logic               sweep_stale;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_addr;
    logic [SW-1:0]      mem_wdata;

    // index decode
    assign in_ext        = IW'(in_blk);
    assign item_ext      = IW'(blk_reg);
    assign item_in_range = ({1'b0, item_ext} < NUM_EXT);

    // stamp compare
    assign gen_prev  = gen_reg - SW'(1);
    assign gen_stale = gen_reg - SW'(2);
    assign in_newer  = (rd_data_reg == gen_reg);
    assign in_older  = (rd_data_reg == gen_prev);

    // mark and rotation
    assign mark_set  = (req_reg == REQ_MARK) && item_in_range && !in_newer;
    assign count_inc = count_reg + COUNT_W'(1);
    assign rotate    = mark_set && (count_inc >= limit_reg[LIMIT_W-1:1]);

    assign sweep_stale = !in_newer && !in_older && (rd_data_reg != gen_stale);

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = sweep_ptr_reg;
        mem_wdata = gen_stale;
        if (cmd.clr_write) begin
            mem_we   = 1'b1;
            mem_addr = clr_ptr_reg;
        end else if (cmd.item_read) begin
            mem_re   = 1'b1;
            mem_addr = in_ext[AW-1:0];
        end else if (cmd.eval) begin
            mem_we    = mark_set;
            mem_addr  = item_ext[AW-1:0];
            mem_wdata = gen_reg;
        end else if (cmd.sweep_read) begin
            mem_re = 1'b1;
        end else if (cmd.sweep_check) begin
            mem_we = sweep_stale;
        end
    end

    // stamp memory, single port with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stamp_mem[mem_addr] <= mem_wdata;
        end else if (mem_re) begin
            rd_data_reg <= stamp_mem[mem_addr];
        end
    end

    // generation and count update
    always_comb begin
        gen_next   = gen_reg;
        count_next = count_reg;
        if (cmd.eval && mark_set) begin
            if (rotate) begin
                gen_next   = gen_reg + SW'(1);
                count_next = '0;
            end else begin
                count_next = count_inc;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg       <= '0;
            count_reg     <= '0;
            clr_ptr_reg   <= '0;
            sweep_ptr_reg <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            gen_reg   <= gen_next;
            count_reg <= count_next;
            if (cmd.clr_write) begin
                clr_ptr_reg <= clr_ptr_reg + AW'(1);
            end
            if (cmd.sweep_check) begin
                sweep_ptr_reg <= (sweep_ptr_reg == LAST_IDX) ? '0
                                                             : sweep_ptr_reg + AW'(1);
            end
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.eval) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge aclk) begin
        if (cmd.item_read) begin
            req_reg <= in_req;
            blk_reg <= in_blk;
        end
        if (cmd.eval) begin
            recent_reg  <= (req_reg == REQ_QUERY) && item_in_range
                           && (in_newer || in_older);
            rotated_reg <= rotate;
        end
    end

    assign sts.clear_last = (clr_ptr_reg == LAST_IDX);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid    = out_valid_reg;
    assign out_recent  = recent_reg;
    assign out_rotated = rotated_reg;

endmodule

// ===== hw/rtl/two_bitmap_recent_block_tracker.sv =====
// ----------------------------------------------------------------------------
// two_bitmap_recent_block_tracker
// Approximate recently-used set of cache blocks kept as two generations.
//
//   channel   direction  tdata                       tuser
//   s_        in         block_index[11:0]           req_type
//   m_        out        is_recent, rotated          -
//   cfg_wr_   in         recent_limit[13:0]          -
//
// Each item passes four steps: accept and stamp read, evaluate and write back,
// one sweep read, one sweep check; all four share the single memory port.
// A result waits in the output register; the evaluate step stalls only
// while that register is full and not taken.
// After reset a clearing pass stamps every entry;
// no item is accepted until it ends.
// ----------------------------------------------------------------------------
module two_bitmap_recent_block_tracker
    import tbrt_pkg::*;
#(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,  // recent_limit
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,      // block_index[11:0], zeros
    input  logic               s_tuser,      // req_type
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata       // is_recent, rotated, zeros
);

    cmd_t cmd;
    sts_t sts;
    logic out_recent;
    logic out_rotated;

    // controller
    tbrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    tbrt_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_req      (s_tuser),
        .in_blk      (s_tdata[BLK_W-1:0]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_recent  (out_recent),
        .out_rotated (out_rotated)
    );

    assign m_tdata = {6'b0, out_rotated, out_recent};

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    // one item at a time: accept is followed by a busy cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item in flight");

    // a result comes only from an evaluation
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.eval))
        else $error("result without evaluation");

    // evaluation never overwrites an untaken result
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval |-> (!m_tvalid || m_tready))
        else $error("result register overrun");

endmodule

// ===== test/two_bitmap_recent_block_tracker_test.sv =====
// ----------------------------------------------------------------------------
// two_bitmap_recent_block_tracker_test
// Self-checking bench for the two-generation recent block tracker. Marks and
// queries are streamed in and each answer is checked against a bit-level
// model of both maps, the newer-map count and the rotation rule. The run
// sweeps several recent_limit values, extremes included, lowers the limit
// while the count is high, and throttles both stream sides at random.
// ----------------------------------------------------------------------------
module two_bitmap_recent_block_tracker_test
    import tbrt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NUM_BLOCKS    = 4096;
    localparam int          HOT_SPAN      = 64;
    localparam int          PHASE_ITEMS   = 95;
    localparam int          NUM_PHASES    = 10;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int unsigned CYCLE_LIMIT   = 500_000;

    // one answer of the tracker as it appears on m_tdata
    typedef struct packed {
        logic rotated;
        logic is_recent;
    } answer_t;

    // model of both maps and the answers still owed by the block
    class tracker_scoreboard;
        bit [NUM_BLOCKS-1:0]  map_a;
        bit [NUM_BLOCKS-1:0]  map_b;
        bit                   newer_is_b;
        bit [COUNT_W-1:0]     newer_count;
        bit [LIMIT_W-1:0]     recent_limit;
        answer_t              owed_answers[$];
        int unsigned          mismatches;

        function new();
            map_a        = '0;
            map_b        = '0;
            newer_is_b   = 1'b0;
            newer_count  = '0;
            recent_limit = LIMIT_RESET;
            mismatches   = 0;
        endfunction

        function void set_limit(bit [LIMIT_W-1:0] value);
            recent_limit = value;
        endfunction

        function int unsigned pending();
            return owed_answers.size();
        endfunction

        function void report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endfunction

        // apply one accepted mark or query and queue its answer
        function void note_item(logic req, logic [BLK_W-1:0] blk);
            answer_t ans;
            bit      in_newer;
            ans = '0;
            if (blk < NUM_BLOCKS) begin
                if (req == REQ_QUERY) begin
                    ans.is_recent = map_a[blk] | map_b[blk];
                end else begin
                    in_newer = newer_is_b ? map_b[blk] : map_a[blk];
                    if (!in_newer) begin
                        if (newer_is_b) map_b[blk] = 1'b1;
                        else map_a[blk] = 1'b1;
                        newer_count = newer_count + 1'b1;
                        // rotate at half the limit, clear the new newer map
                        if (newer_count >= (recent_limit >> 1)) begin
                            newer_is_b = !newer_is_b;
                            if (newer_is_b) map_b = '0;
                            else map_a = '0;
                            newer_count = '0;
                            ans.rotated = 1'b1;
                        end
                    end
                end
            end
            owed_answers.push_back(ans);
        endfunction

        // compare one result with the oldest owed answer
        function void check_result(logic [7:0] data);
            answer_t want;
            if (owed_answers.size() == 0) begin
                report_mismatch($sformatf("result 0x%02h with nothing owed", data));
                return;
            end
            want = owed_answers.pop_front();
            if (data[0] !== want.is_recent)
                report_mismatch($sformatf("is_recent %b, want %b", data[0], want.is_recent));
            if (data[1] !== want.rotated)
                report_mismatch($sformatf("rotated %b, want %b", data[1], want.rotated));
        endfunction
    endclass

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata     = '0;   // block_index[11:0], zeros
    logic               s_tuser     = 1'b0; // req_type
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [7:0]         m_tdata;            // is_recent, rotated, zeros

    tracker_scoreboard  sb = new();
    bit                 sender_idle_on   = 1'b0;
    bit                 receiver_idle_on = 1'b0;
    int unsigned        cycle_count      = 0;

    two_bitmap_recent_block_tracker #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    always #2 aclk = ~aclk;

    // idle stretch: mostly short, now and then long
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // present one item and hold it until taken
    task automatic send_item(logic req, logic [BLK_W-1:0] blk);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(16 - BLK_W){1'b0}}, blk};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sb.note_item(req, blk);
    endtask

    // optional gap after an item
    task automatic sender_gap();
        int unsigned n;
        n = 0;
        if (sender_idle_on && $urandom_range(0, 2) == 0) n = idle_len();
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // stop sending until every owed answer is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_limit(value);
    endtask

    // result side: check taken results, then pick tready for the next edge
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            if (stall_left == 0 && receiver_idle_on && $urandom_range(0, 3) == 0)
                stall_left = idle_len();
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial begin
        logic [LIMIT_W-1:0] phase_limits [NUM_PHASES];
        logic [BLK_W-1:0]   hot_base;
        logic [BLK_W-1:0]   blk;
        logic               req;

        phase_limits = '{14'd20, 14'd0, 14'd1, 14'h3FFF, 14'd200,
                         14'd8192, 14'd3, 14'd2, 14'd100, 14'd100};
        phase_limits[NUM_PHASES-1] = LIMIT_W'($urandom_range(100, 8192));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // threshold of three marks
        write_limit(14'd6);
        send_item(REQ_QUERY, 12'd0);
        send_item(REQ_QUERY, 12'hFFF);
        send_item(REQ_MARK, 12'd0);
        send_item(REQ_MARK, 12'd0);        // already in newer map
        send_item(REQ_MARK, 12'hFFF);
        send_item(REQ_QUERY, 12'd0);
        send_item(REQ_QUERY, 12'hFFF);
        send_item(REQ_MARK, 12'd2048);     // third distinct mark rotates
        send_item(REQ_QUERY, 12'd0);       // still found in older map
        send_item(REQ_MARK, 12'd0);
        send_item(REQ_MARK, 12'd5);
        send_item(REQ_MARK, 12'd7);        // second rotation drops first set
        send_item(REQ_QUERY, 12'hFFF);
        send_item(REQ_QUERY, 12'd5);

        // zero limit: every new mark rotates
        wait_drained();
        write_limit(14'd0);
        send_item(REQ_MARK, 12'd100);
        send_item(REQ_MARK, 12'd100);
        send_item(REQ_QUERY, 12'd100);

        // limit of one behaves the same
        wait_drained();
        write_limit(14'd1);
        send_item(REQ_MARK, 12'd200);
        send_item(REQ_QUERY, 12'd200);

        // large limit, then lowered so that half of it is below the running count
        wait_drained();
        write_limit(14'h3FFF);
        for (int i = 1; i <= 6; i++) send_item(REQ_MARK, BLK_W'(i));
        wait_drained();
        write_limit(14'd8);
        send_item(REQ_MARK, 12'd11);
        send_item(REQ_QUERY, 12'd3);

        // random phases, one limit each
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_limit(phase_limits[p]);
            sender_idle_on   = (p != 0) && ($urandom_range(0, 3) != 0);
            receiver_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
            hot_base = BLK_W'($urandom_range(0, NUM_BLOCKS - HOT_SPAN));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                req = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 65)
                    blk = hot_base + BLK_W'($urandom_range(0, HOT_SPAN - 1));
                else
                    blk = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
                send_item(req, blk);
                if ($urandom_range(0, 49) == 0) wait_drained();
                else sender_gap();
            end
        end

        // drain and settle
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tbrt_pkg.sv
hw/rtl/tbrt_ctrl.sv
hw/rtl/tbrt_dpath.sv
hw/rtl/two_bitmap_recent_block_tracker.sv
test/two_bitmap_recent_block_tracker_test.sv
